>>> rtl/lzte_pkg.sv
// shared constants, command and status types for the lz token bitstream encoder
package lzte_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = QAW + 1;
  localparam logic [QCW-1:0] QCNT_ONE  = 1;
  localparam logic [QCW-1:0] QCNT_FULL = QUEUE_DEPTH[QCW-1:0];

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_VARIANT = 1'b1;

  localparam logic [4:0] OFFB_MIN   = 5'd8;
  localparam logic [4:0] OFFB_MAX   = 5'd16;
  localparam logic [4:0] OFFB_RESET = 5'd16;
  localparam logic [4:0] SH_LOAD_BASE = 5'd17;

  localparam logic [1:0] OP_LIT   = 2'd0;
  localparam logic [1:0] OP_MATCH = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [16:0] END_GAMMA   = 17'd255;
  localparam logic [4:0]  GAMMA_TOP   = 5'd16;
  localparam logic [3:0]  FLAG_FULL   = 4'd8;
  localparam logic [15:0] LONG_OFFSET = 16'd128;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_BIT,
    CMD_BYTE_LIT,
    CMD_BYTE_OFF,
    CMD_GLOAD,
    CMD_NORM,
    CMD_OLOAD,
    CMD_FLUSH,
    CMD_FINISH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    bit_val;
    logic    shift;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic started;
    logic is_end;
    logic long_off;
    logic variant;
    logic sh_top;
    logic norm_done;
    logic cnt_zero;
    logic cnt_one;
  } dp_stat_t;

endpackage

>>> rtl/lzte_if.sv
// request channel interfaces: token input and byte output
interface lzte_tok_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  literal;
  logic [16:0] match_length;
  logic [15:0] match_offset;

  modport source (output valid, output op, output literal, output match_length,
                  output match_offset, input ready);
  modport sink (input valid, input op, input literal, input match_length,
                input match_offset, output ready);
endinterface

interface lzte_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input stream_done,
                output ready);
endinterface

>>> rtl/lz_token_bitstream_encoder_top.sv
// top level of the lz token bitstream encoder
//
//  channel   dir  handshake      payload
//  in_tok    in   valid/ready    op, literal, match_length, match_offset
//  out_ch    out  valid/ready    out_byte, run_last, stream_done
//  cfg_*     in   cfg_we         cfg_index (0 offset_bits, 1 gamma_variant), cfg_wdata
//
// one token at a time; in_tok.ready is high only while the sequencer is idle
// literal: a 0 flag bit (none for the first of a stream), then the literal byte
// match or end: a 1 flag bit, gamma load, normalise, gamma bits, stop bit; a match adds
// its offset byte, a long one offset_bits - 8 more bits; one bit per cycle unless busy
// a full flag byte drains the flag, then the queued bytes, one per cycle unless stalled
// output stalls hold the whole token; sync active-low reset, no clearing pass
module lz_token_bitstream_encoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  lzte_tok_if.sink                        in_tok,
  lzte_byte_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [lzte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lzte_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lzte_pkg::dp_cmd_t  cmd;
  lzte_pkg::dp_stat_t stat;

  lzte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tok.valid),
    .in_op    (in_tok.op),
    .in_ready (in_tok.ready),
    .st       (stat),
    .cmd      (cmd)
  );

  lzte_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .tok_op      (in_tok.op),
    .tok_literal (in_tok.literal),
    .tok_length  (in_tok.match_length),
    .tok_offset  (in_tok.match_offset),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .run_last    (out_ch.run_last),
    .stream_done (out_ch.stream_done)
  );

endmodule

>>> rtl/lzte_dp.sv
// datapath: config, token latch, gamma/offset shifter, flag byte, byte queue, output stage
module lzte_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lzte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lzte_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [1:0]                          tok_op,
  input  logic [7:0]                          tok_literal,
  input  logic [16:0]                         tok_length,
  input  logic [15:0]                         tok_offset,
  input  lzte_pkg::dp_cmd_t                   cmd,
  output lzte_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte,
  output logic                                run_last,
  output logic                                stream_done
);

  // configuration
  logic [4:0] offb_r;
  logic       var_r;

  // token
  logic [1:0]  op_r;
  logic [7:0]  lit_r;
  logic [16:0] len_r;
  logic [15:0] o_r;
  logic        started_r, started_nxt;

  // flag byte and waiting queue
  logic [7:0]               flag_r, flag_nxt;
  logic [3:0]               used_r, used_nxt;
  logic [7:0]               queue_mem [lzte_pkg::QUEUE_DEPTH];
  logic [lzte_pkg::QCW-1:0] cnt_q_r, cnt_q_nxt;
  logic [lzte_pkg::QCW-1:0] dr_ptr_r, dr_ptr_nxt;
  logic                     dr_sent_r, dr_sent_nxt;
  logic [7:0]               rd_q_r;

  // shared shifter for gamma and offset bits
  logic [16:0] sh_r, sh_nxt;
  logic [4:0]  gcnt_r, gcnt_nxt;

  // held byte and output register
  logic [7:0] hold_r, hold_nxt;
  logic       hold_v_r, hold_v_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       ov_r, ov_nxt;
  logic       olast_r, olast_nxt;
  logic       odone_r, odone_nxt;

  logic        out_free, stall, draining, busy, go, drain_adv;
  logic        byte_cmd, q_push, rel_v, long_off, norm_done;
  logic [7:0]  rel_b, byte_val, off_byte;
  logic [16:0] u_val, u_min1, gval;
  logic [15:0] d_val;
  logic [4:0]  obc, oshift;

  assign out_free  = !ov_r || out_ready;
  assign stall     = hold_v_r && !out_free;
  assign draining  = (used_r == lzte_pkg::FLAG_FULL);
  assign busy      = draining || stall;
  assign go        = !busy;
  assign drain_adv = draining && !stall;

  assign long_off  = |o_r[15:7];
  assign off_byte  = long_off ? {1'b1, o_r[6:0]} : o_r[7:0];
  assign byte_cmd  = (cmd.op == lzte_pkg::CMD_BYTE_LIT) || (cmd.op == lzte_pkg::CMD_BYTE_OFF);
  assign byte_val  = (cmd.op == lzte_pkg::CMD_BYTE_LIT) ? lit_r : off_byte;
  assign q_push    = go && byte_cmd && (used_r != 4'd0) && (cnt_q_r < lzte_pkg::QCNT_FULL);
  assign norm_done = sh_r[16] || (gcnt_r == 5'd0);

  // gamma value: bijective form is coded as (max(v,1)-1)+2 with its top bit dropped
  always_comb begin
    if (op_r == lzte_pkg::OP_END) u_val = lzte_pkg::END_GAMMA;
    else if (len_r == 17'd0) u_val = 17'd0;
    else u_val = len_r - 17'd1;
    u_min1 = (u_val == 17'd0) ? 17'd1 : u_val;
    gval   = var_r ? u_min1 + 17'd1 : u_val;
  end

  always_comb begin
    if (offb_r < lzte_pkg::OFFB_MIN) obc = lzte_pkg::OFFB_MIN;
    else if (offb_r > lzte_pkg::OFFB_MAX) obc = lzte_pkg::OFFB_MAX;
    else obc = offb_r;
    oshift = lzte_pkg::SH_LOAD_BASE - obc;
    d_val  = o_r - lzte_pkg::LONG_OFFSET;
  end

  // byte release: drain has priority, controller steps are held off while draining
  always_comb begin
    rel_v = 1'b0;
    rel_b = byte_val;
    if (drain_adv && !dr_sent_r) begin
      rel_v = 1'b1;
      rel_b = flag_r;
    end else if (drain_adv && (dr_ptr_r < cnt_q_r)) begin
      rel_v = 1'b1;
      rel_b = rd_q_r;
    end else if (go && byte_cmd && (used_r == 4'd0)) begin
      rel_v = 1'b1;
    end
  end

  // the newest released byte is held back until we know whether it ends the token
  always_comb begin
    ov_nxt     = ov_r && !out_ready;
    ob_nxt     = ob_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    if (rel_v) begin
      if (hold_v_r) begin
        ov_nxt    = 1'b1;
        ob_nxt    = hold_r;
        olast_nxt = 1'b0;
        odone_nxt = 1'b0;
      end
      hold_nxt   = rel_b;
      hold_v_nxt = 1'b1;
    end else if (go && (cmd.op == lzte_pkg::CMD_FINISH) && hold_v_r) begin
      ov_nxt     = 1'b1;
      ob_nxt     = hold_r;
      olast_nxt  = 1'b1;
      odone_nxt  = (op_r == lzte_pkg::OP_END);
      hold_v_nxt = 1'b0;
    end
  end

  always_comb begin
    flag_nxt    = flag_r;
    used_nxt    = used_r;
    cnt_q_nxt   = cnt_q_r;
    dr_sent_nxt = dr_sent_r;
    dr_ptr_nxt  = dr_ptr_r;
    started_nxt = started_r;
    if (drain_adv) begin
      if (!dr_sent_r) begin
        dr_sent_nxt = 1'b1;
      end else if (dr_ptr_r < cnt_q_r) begin
        dr_ptr_nxt = dr_ptr_r + lzte_pkg::QCNT_ONE;
      end else begin
        used_nxt    = 4'd0;
        flag_nxt    = 8'd0;
        cnt_q_nxt   = '0;
        dr_sent_nxt = 1'b0;
        dr_ptr_nxt  = '0;
      end
    end else if (go) begin
      if (cmd.op == lzte_pkg::CMD_BIT) begin
        if (cmd.bit_val) flag_nxt = flag_r | (8'h80 >> used_r);
        used_nxt = used_r + 4'd1;
      end
      if (q_push) cnt_q_nxt = cnt_q_r + lzte_pkg::QCNT_ONE;
      if ((cmd.op == lzte_pkg::CMD_FLUSH) && (used_r != 4'd0)) used_nxt = lzte_pkg::FLAG_FULL;
      if (cmd.op == lzte_pkg::CMD_FINISH) started_nxt = (op_r != lzte_pkg::OP_END);
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    gcnt_nxt = gcnt_r;
    if (go) begin
      unique case (cmd.op)
        lzte_pkg::CMD_GLOAD: begin
          sh_nxt   = gval;
          gcnt_nxt = lzte_pkg::GAMMA_TOP;
        end
        lzte_pkg::CMD_NORM: begin
          if (!norm_done) begin
            sh_nxt   = {sh_r[15:0], 1'b0};
            gcnt_nxt = gcnt_r - 5'd1;
          end
        end
        lzte_pkg::CMD_BIT: begin
          if (cmd.shift) begin
            sh_nxt   = {sh_r[15:0], 1'b0};
            gcnt_nxt = gcnt_r - 5'd1;
          end
        end
        lzte_pkg::CMD_OLOAD: begin
          // top coded offset bit lands at bit 15
          sh_nxt   = {1'b0, d_val} << oshift;
          gcnt_nxt = obc - lzte_pkg::OFFB_MIN;
        end
        default: begin
          sh_nxt   = sh_r;
          gcnt_nxt = gcnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offb_r    <= lzte_pkg::OFFB_RESET;
      var_r     <= 1'b0;
      started_r <= 1'b0;
      flag_r    <= 8'd0;
      used_r    <= 4'd0;
      cnt_q_r   <= '0;
      dr_sent_r <= 1'b0;
      dr_ptr_r  <= '0;
      hold_v_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == lzte_pkg::CFG_OFFSET_BITS)) offb_r <= cfg_wdata;
      if (cfg_we && (cfg_index == lzte_pkg::CFG_GAMMA_VARIANT)) var_r <= cfg_wdata[0];
      started_r <= started_nxt;
      flag_r    <= flag_nxt;
      used_r    <= used_nxt;
      cnt_q_r   <= cnt_q_nxt;
      dr_sent_r <= dr_sent_nxt;
      dr_ptr_r  <= dr_ptr_nxt;
      hold_v_r  <= hold_v_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (cmd.op == lzte_pkg::CMD_LOAD)) begin
      op_r  <= tok_op;
      lit_r <= tok_literal;
      len_r <= tok_length;
      o_r   <= tok_offset - 16'd1;
    end
    sh_r    <= sh_nxt;
    gcnt_r  <= gcnt_nxt;
    hold_r  <= hold_nxt;
    ob_r    <= ob_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  // waiting byte queue
  always_ff @(posedge clk) begin
    if (q_push) queue_mem[cnt_q_r[lzte_pkg::QAW-1:0]] <= byte_val;
    rd_q_r <= queue_mem[dr_ptr_nxt[lzte_pkg::QAW-1:0]];
  end

  assign stat.busy      = busy;
  assign stat.started   = started_r;
  assign stat.is_end    = (op_r == lzte_pkg::OP_END);
  assign stat.long_off  = long_off;
  assign stat.variant   = var_r;
  assign stat.sh_top    = sh_r[15];
  assign stat.norm_done = norm_done;
  assign stat.cnt_zero  = (gcnt_r == 5'd0);
  assign stat.cnt_one   = (gcnt_r == 5'd1);

  assign out_valid   = ov_r;
  assign out_byte    = ob_r;
  assign run_last    = olast_r;
  assign stream_done = odone_r;

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= lzte_pkg::FLAG_FULL)
    else $error("flag bit count out of range");

  a_queue_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_q_r <= lzte_pkg::QCNT_FULL)
    else $error("waiting queue overfilled");

  a_queue_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_q_r != '0) |-> (used_r != 4'd0))
    else $error("bytes waiting with no flag byte open");

  a_finish_empties_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (cmd.op == lzte_pkg::CMD_FINISH)) |=> !hold_v_r)
    else $error("held byte left behind at end of token");

endmodule

>>> rtl/lzte_ctrl.sv
// controller: per-token sequencer issuing bit, byte, gamma and offset commands
module lzte_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  output logic               in_ready,
  input  lzte_pkg::dp_stat_t st,
  output lzte_pkg::dp_cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_LITBIT  = 15'h0002,
    S_LITBYTE = 15'h0004,
    S_MFLAG   = 15'h0008,
    S_GLOAD   = 15'h0010,
    S_NORM    = 15'h0020,
    S_GFIRST  = 15'h0040,
    S_GZERO   = 15'h0080,
    S_GBIT    = 15'h0100,
    S_GSTOP   = 15'h0200,
    S_OFFBYTE = 15'h0400,
    S_OLOAD   = 15'h0800,
    S_OBIT    = 15'h1000,
    S_FLUSH   = 15'h2000,
    S_FINISH  = 15'h4000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = lzte_pkg::CMD_NOP;
    cmd.bit_val = 1'b0;
    cmd.shift   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = lzte_pkg::CMD_LOAD;
          priority if (in_op == lzte_pkg::OP_LIT) begin
            state_nxt = st.started ? S_LITBIT : S_LITBYTE;
          end else if ((in_op == lzte_pkg::OP_MATCH) || (in_op == lzte_pkg::OP_END)) begin
            state_nxt = S_MFLAG;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LITBIT: begin
        cmd.op    = lzte_pkg::CMD_BIT;
        state_nxt = S_LITBYTE;
      end
      S_LITBYTE: begin
        cmd.op    = lzte_pkg::CMD_BYTE_LIT;
        state_nxt = S_FINISH;
      end
      S_MFLAG: begin
        cmd.op      = lzte_pkg::CMD_BIT;
        cmd.bit_val = 1'b1;
        state_nxt   = S_GLOAD;
      end
      S_GLOAD: begin
        cmd.op    = lzte_pkg::CMD_GLOAD;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        // shift left until the leading one reaches the top or the count runs out
        cmd.op = lzte_pkg::CMD_NORM;
        if (st.norm_done) begin
          if (st.variant) state_nxt = S_GFIRST;
          else state_nxt = st.cnt_zero ? S_GSTOP : S_GZERO;
        end
      end
      S_GFIRST: begin
        cmd.op      = lzte_pkg::CMD_BIT;
        cmd.bit_val = st.sh_top;
        cmd.shift   = 1'b1;
        state_nxt   = st.cnt_one ? S_GSTOP : S_GZERO;
      end
      S_GZERO: begin
        cmd.op    = lzte_pkg::CMD_BIT;
        state_nxt = S_GBIT;
      end
      S_GBIT: begin
        cmd.op      = lzte_pkg::CMD_BIT;
        cmd.bit_val = st.sh_top;
        cmd.shift   = 1'b1;
        state_nxt   = st.cnt_one ? S_GSTOP : S_GZERO;
      end
      S_GSTOP: begin
        cmd.op      = lzte_pkg::CMD_BIT;
        cmd.bit_val = 1'b1;
        state_nxt   = st.is_end ? S_FLUSH : S_OFFBYTE;
      end
      S_OFFBYTE: begin
        cmd.op    = lzte_pkg::CMD_BYTE_OFF;
        state_nxt = st.long_off ? S_OLOAD : S_FINISH;
      end
      S_OLOAD: begin
        cmd.op    = lzte_pkg::CMD_OLOAD;
        state_nxt = S_OBIT;
      end
      S_OBIT: begin
        if (st.cnt_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op      = lzte_pkg::CMD_BIT;
          cmd.bit_val = st.sh_top;
          cmd.shift   = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd.op    = lzte_pkg::CMD_FLUSH;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.op    = lzte_pkg::CMD_FINISH;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // datapath ignores commands while busy, so hold the step
    if (st.busy) state_nxt = state_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !st.busy)
    else $error("datapath busy while waiting for a token");

  a_busy_holds_step: assert property (@(posedge clk) disable iff (!rst_n)
    st.busy |=> $stable(state_r))
    else $error("sequencer advanced while datapath busy");

endmodule
